// ===== rtl/core/hlfd_pkg.sv =====
// Shared types and constants for the header/length frame detector.
// Holds the beat structs, the controller state enums and the command/status bundles.
// No dependencies.
`default_nettype none

package hlfd_pkg;

   // Input opcodes.
   localparam logic OP_FEED  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_MASK_LO     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MASK_MID_LO = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MASK_MID_HI = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MASK_HI     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_OUT_LIMIT   = 3'd4;

   localparam int unsigned CSR_DW = 64;
   localparam int unsigned LIMIT_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       from_flush;
   } rsp_type;

   // Frame parsing phase.
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_COLLECT
   } phase_type;

   // Emission sequencer state.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_header;
      logic wr_length;
      logic wr_payload;
      logic clear;
      logic emit_start;
      logic emit_flush;
      logic rd_issue;
      logic rd_next;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic header_hit;
      logic len_zero;
      logic len_big;
      logic count_done;
      logic limit_zero;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/hlfd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the frame store; no dependencies.
`default_nettype none

module hlfd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hlfd_datapath.sv =====
// Datapath of the frame detector: configuration registers, frame counters,
// frame store and the output register. Depends on hlfd_pkg and hlfd_ram.
`default_nettype none

module hlfd_datapath #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [hlfd_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [hlfd_pkg::CSR_DW-1:0]  csr_wdata,
   input  wire logic [7:0]                   data_byte,
   input  wire hlfd_pkg::cmd_type            cmd,
   output hlfd_pkg::status_type              status,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output hlfd_pkg::rsp_type                 rsp_data
);

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);
   localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 2);
   localparam logic [CW-1:0] FILL_MAX = CW'(MAX_FRAME);

   logic [63:0] mask0_ff, mask1_ff, mask2_ff, mask3_ff;
   logic [hlfd_pkg::LIMIT_W-1:0] limit_ff;

   logic [7:0]    length_ff, length_in;
   logic [7:0]    count_ff, count_in;
   logic [CW-1:0] fill_ff, fill_in, fill_upd;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] emit_len_ff, emit_len_in;
   logic          flush_ff, flush_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hlfd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [255:0]  mask_all;
   logic [CW-1:0] idx_plus;
   logic [7:0]    count_plus;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask0_ff <= '0;
         mask1_ff <= '0;
         mask2_ff <= '0;
         mask3_ff <= '0;
         limit_ff <= hlfd_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            hlfd_pkg::CSR_MASK_LO:     mask0_ff <= csr_wdata;
            hlfd_pkg::CSR_MASK_MID_LO: mask1_ff <= csr_wdata;
            hlfd_pkg::CSR_MASK_MID_HI: mask2_ff <= csr_wdata;
            hlfd_pkg::CSR_MASK_HI:     mask3_ff <= csr_wdata;
            hlfd_pkg::CSR_OUT_LIMIT:   limit_ff <= csr_wdata[hlfd_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign mask_all   = {mask3_ff, mask2_ff, mask1_ff, mask0_ff};
   assign idx_plus   = idx_ff + CW'(1);
   assign count_plus = count_ff + 8'd1;

   always_comb begin
      status.header_hit = mask_all[data_byte];
      status.len_zero   = (data_byte == 8'd0);
      status.len_big    = (data_byte > LEN_MAX);
      status.count_done = (count_plus >= length_ff);
      status.limit_zero = (limit_ff == '0);
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.emit_last  = (idx_plus == emit_len_ff);
   end

   // Fill level after this beat's store write, before any clear.
   always_comb begin
      fill_upd = fill_ff;
      if (cmd.wr_header) begin
         fill_upd = CW'(1);
      end else if (cmd.wr_length) begin
         fill_upd = CW'(2);
      end else if (cmd.wr_payload && (fill_ff < FILL_MAX)) begin
         fill_upd = fill_ff + CW'(1);
      end
   end

   always_comb begin
      length_in   = length_ff;
      count_in    = count_ff;
      fill_in     = fill_upd;
      idx_in      = idx_ff;
      emit_len_in = emit_len_ff;
      flush_in    = flush_ff;
      if (cmd.wr_length) begin
         length_in = data_byte;
         count_in  = 8'd0;
      end else if (cmd.wr_payload) begin
         count_in = count_plus;
      end
      if (cmd.clear) begin
         length_in = 8'd0;
         count_in  = 8'd0;
         fill_in   = '0;
      end
      if (cmd.emit_start) begin
         idx_in   = '0;
         flush_in = cmd.emit_flush;
         if (7'(fill_upd) > limit_ff) begin
            emit_len_in = limit_ff[CW-1:0];
         end else begin
            emit_len_in = fill_upd;
         end
      end else if (cmd.rd_next) begin
         idx_in = idx_plus;
      end
   end

   // Output register: a loaded beat waits here until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_byte   = ram_rdata;
         rsp_data_in.last_byte  = status.emit_last;
         rsp_data_in.from_flush = flush_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         emit_len_ff  <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         emit_len_ff  <= emit_len_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Frame store write and read addressing.
   always_comb begin
      ram_we    = cmd.wr_header || cmd.wr_length || (cmd.wr_payload && (fill_ff < FILL_MAX));
      ram_waddr = fill_ff[AW-1:0];
      if (cmd.wr_header) begin
         ram_waddr = AW'(0);
      end else if (cmd.wr_length) begin
         ram_waddr = AW'(1);
      end
      ram_raddr = cmd.rd_next ? idx_plus[AW-1:0] : idx_ff[AW-1:0];
   end

   hlfd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (data_byte),
      .rd_en   (cmd.rd_issue || cmd.rd_next),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hlfd_ctrl.sv =====
// Controller of the frame detector: frame parsing phase and emission sequencer.
// Depends on hlfd_pkg.
`default_nettype none

module hlfd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_opcode,
   output logic                      req_ready,
   input  wire hlfd_pkg::status_type status,
   output hlfd_pkg::cmd_type         cmd
);

   hlfd_pkg::state_type state_ff, state_in;
   hlfd_pkg::phase_type phase_ff, phase_in;

   logic accept;
   logic is_flush;
   logic finish;
   logic drop;
   logic emit;

   // Decisions shared by the next-state and output logic.
   always_comb begin
      accept   = req_valid && (state_ff == hlfd_pkg::ST_IDLE);
      is_flush = (req_opcode == hlfd_pkg::OP_FLUSH);
      finish   = 1'b0;
      drop     = 1'b0;
      case (phase_ff)
         hlfd_pkg::PH_HEADER: begin
            finish = is_flush || status.len_zero;
            drop   = !is_flush && !status.len_zero && status.len_big;
         end
         hlfd_pkg::PH_COLLECT: begin
            finish = is_flush || status.count_done;
         end
         default: begin
            finish = 1'b0;
         end
      endcase
      finish = accept && finish;
      drop   = accept && drop;
      emit   = finish && !status.limit_zero;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         hlfd_pkg::ST_IDLE: begin
            if (emit) begin
               state_in = hlfd_pkg::ST_READ;
            end
         end
         hlfd_pkg::ST_READ: begin
            state_in = hlfd_pkg::ST_LOAD;
         end
         hlfd_pkg::ST_LOAD: begin
            if (status.out_free && status.emit_last) begin
               state_in = hlfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hlfd_pkg::ST_IDLE;
         end
      endcase
      if (accept) begin
         if (is_flush || finish || drop) begin
            phase_in = hlfd_pkg::PH_HUNT;
         end else begin
            case (phase_ff)
               hlfd_pkg::PH_HUNT: begin
                  if (status.header_hit) begin
                     phase_in = hlfd_pkg::PH_HEADER;
                  end
               end
               hlfd_pkg::PH_HEADER: begin
                  phase_in = hlfd_pkg::PH_COLLECT;
               end
               hlfd_pkg::PH_COLLECT: begin
                  phase_in = hlfd_pkg::PH_COLLECT;
               end
               default: begin
                  phase_in = hlfd_pkg::PH_HUNT;
               end
            endcase
         end
      end
   end

   // Outputs.
   always_comb begin
      req_ready      = (state_ff == hlfd_pkg::ST_IDLE);
      cmd            = '0;
      cmd.clear      = accept && (is_flush || finish || drop);
      cmd.emit_start = emit;
      cmd.emit_flush = is_flush;
      if (accept && !is_flush) begin
         case (phase_ff)
            hlfd_pkg::PH_HEADER:  cmd.wr_length  = 1'b1;
            hlfd_pkg::PH_COLLECT: cmd.wr_payload = 1'b1;
            default:              cmd.wr_header  = status.header_hit;
         endcase
      end
      case (state_ff)
         hlfd_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
         end
         hlfd_pkg::ST_LOAD: begin
            cmd.load_out = status.out_free;
            cmd.rd_next  = status.out_free && !status.emit_last;
         end
         default: begin
            cmd.rd_issue = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hlfd_pkg::ST_IDLE;
         phase_ff <= hlfd_pkg::PH_HUNT;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/header_length_frame_detector_unit.sv =====
// Header/length frame detector, top level. Depends on hlfd_pkg, hlfd_ctrl, hlfd_datapath.
// A beat that does not complete a frame leaves the block ready for the next beat. A completing
// beat (or a flush with content) is accepted, then the sequencer issues the first frame
// store read, then emits one byte per cycle from the store while the consumer is ready.
// The first result beat passes the store's read register and then the output register.
// Synchronous active-high reset clears all control state; no clearing pass is needed.
`default_nettype none

module header_length_frame_detector_unit #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Input stream beats.
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire hlfd_pkg::req_type           req_data,
   // Result beats.
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output hlfd_pkg::rsp_type                rsp_data,
   // Configuration writes.
   input  wire logic                        csr_we,
   input  wire logic [hlfd_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [hlfd_pkg::CSR_DW-1:0] csr_wdata
);

   // The controller owns the parsing phase (hunting, header seen, collecting) and the
   // emission sequencer. The datapath owns the counters, the header mask, the frame
   // store and the output register, and reports flags back to the controller.
   hlfd_pkg::cmd_type    cmd;
   hlfd_pkg::status_type status;

   hlfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The output register lets the block accept a new input beat while the final byte
   // of the previous frame still waits for the consumer.
   hlfd_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .data_byte (req_data.data_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
